// ===== sv/gbbs_pkg.sv =====
// Shared constants and types for the grid bracket binary search block.
// No dependencies; every other file but gbbs_ram imports this package.
package gbbs_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
    localparam logic [LEN_W-1:0] LEN_MIN   = 11'd2;
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(DEPTH);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  wdata;
    } t_ram_req;

endpackage

// ===== sv/gbbs_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; width and depth come from its parameters.
module gbbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gbbs_search.sv =====
// Search sequencer: takes input transactions, drives the grid RAM port and
// runs one probe per cycle through a shared compare/add unit. Uses gbbs_pkg.
module gbbs_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [gbbs_pkg::IDX_W-1:0] i_entry_index,
    input  logic signed [gbbs_pkg::VAL_W-1:0] i_value,
    input  logic [gbbs_pkg::LEN_W-1:0] i_len,
    output gbbs_pkg::t_ram_req         o_ram_req,
    input  logic [gbbs_pkg::VAL_W-1:0] i_ram_rdata,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [gbbs_pkg::IDX_W-1:0] o_lower_index,
    output logic [gbbs_pkg::IDX_W-1:0] o_upper_index
);
    import gbbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_first;
    logic [LEN_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_probe;
    logic signed [VAL_W-1:0] r_value;
    logic [IDX_W-1:0]   r_upper;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_lower;
    logic [IDX_W-1:0]   r_out_upper;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic               entry_lt;
    logic [LEN_W-1:0]   half;
    logic [LEN_W-1:0]   n_first;
    logic [LEN_W-1:0]   n_count;
    logic [LEN_W-1:0]   n_probe;
    logic [LEN_W-1:0]   start_probe;
    logic [LEN_W-1:0]   upper_fin;
    logic               idx_ok;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    // load the output register when a search finishes or a held result moves out
    assign out_load = out_free &&
                      ((r_state == ST_SEARCH && n_count == '0) || r_state == ST_HOLD);

    // Shared probe unit: compare the entry just read, narrow the range,
    // and form the next probe address.
    always_comb begin
        half     = r_count >> 1;
        entry_lt = $signed(i_ram_rdata) < r_value;
        if (entry_lt) begin
            n_first = LEN_W'(r_probe) + LEN_W'(1);
            n_count = r_count - half - LEN_W'(1);
        end else begin
            n_first = r_first;
            n_count = half;
        end
        n_probe     = n_first + (n_count >> 1);
        start_probe = LEN_W'(1) + ((i_len - LEN_W'(1)) >> 1);
        upper_fin   = (n_first == r_len) ? (r_len - LEN_W'(1)) : n_first;
        idx_ok      = (LEN_W'(i_entry_index) < LEN_MAX);
    end

    always_comb begin
        o_ram_req.we    = 1'b0;
        o_ram_req.addr  = n_probe[ADDR_W-1:0];
        o_ram_req.wdata = i_value;
        if (r_state == ST_IDLE) begin
            if (accept && i_action == ACT_WRITE) begin
                o_ram_req.we   = idx_ok;
                o_ram_req.addr = ADDR_W'(i_entry_index);
            end else begin
                o_ram_req.addr = start_probe[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_action == ACT_SEARCH) begin
                        r_first <= LEN_W'(1);
                        r_count <= i_len - LEN_W'(1);
                        r_len   <= i_len;
                        r_probe <= start_probe[ADDR_W-1:0];
                        r_value <= i_value;
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    r_first <= n_first;
                    r_count <= n_count;
                    r_probe <= n_probe[ADDR_W-1:0];
                    if (n_count == '0) begin
                        r_upper <= IDX_W'(upper_fin);
                        if (out_free) begin
                            r_out_upper <= IDX_W'(upper_fin);
                            r_out_lower <= IDX_W'(upper_fin - LEN_W'(1));
                            r_state     <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    // hold the finished result until the output register frees
                    if (out_free) begin
                        r_out_upper <= r_upper;
                        r_out_lower <= r_upper - IDX_W'(1);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_lower_index = r_out_lower;
    assign o_upper_index = r_out_upper;

endmodule

// ===== sv/grid_bracket_binary_search.sv =====
// Top level of the grid bracket binary search block: grid length register,
// grid RAM and search sequencer. Uses gbbs_pkg, gbbs_ram and gbbs_search.
//
// Usage:
// - Input channel (i_valid/o_ready) carries i_action, i_entry_index, i_value.
//   A write transaction stores i_value at i_entry_index and gives no result.
//   A search transaction brackets i_value in the ascending Q16.16 grid.
// - Output channel (o_valid/i_ready) carries o_lower_index and o_upper_index,
//   one transaction per search.
// - Config channel (i_cfg_valid/o_cfg_ready) writes the grid length; it is
//   always ready. The user writes it only while the block is idle; the block does not enforce this.
// - A search runs one probe per cycle, paced by the registered read of the
//   single-port grid RAM feeding the compare unit. The input channel is not
//   ready while a search runs.
// - A finished result sits in an output register; new transactions are taken
//   while it waits. If the receiver stalls and a second search finishes, the
//   sequencer holds that result and stays not ready until the register frees.
// - Reset clears the control state and sets the grid length to 1024. Grid
//   contents are undefined until written; no clearing pass runs.
module grid_bracket_binary_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [gbbs_pkg::IDX_W-1:0] i_entry_index,
    input  logic signed [gbbs_pkg::VAL_W-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [gbbs_pkg::IDX_W-1:0] o_lower_index,
    output logic [gbbs_pkg::IDX_W-1:0] o_upper_index,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gbbs_pkg::LEN_W-1:0] i_cfg_grid_length
);
    import gbbs_pkg::*;

    logic [LEN_W-1:0] r_grid_length;
    logic [LEN_W-1:0] len_use;
    t_ram_req         ram_req;
    logic [VAL_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_length <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_length <= i_cfg_grid_length;
        end
    end

    // clamp the length in use to the searchable range
    always_comb begin
        if (r_grid_length < LEN_MIN) begin
            len_use = LEN_MIN;
        end else if (r_grid_length > LEN_MAX) begin
            len_use = LEN_MAX;
        end else begin
            len_use = r_grid_length;
        end
    end

    gbbs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    gbbs_search u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_value       (i_value),
        .i_len         (len_use),
        .o_ram_req     (ram_req),
        .i_ram_rdata   (ram_rdata),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_lower_index (o_lower_index),
        .o_upper_index (o_upper_index)
    );

endmodule

// ===== dv/gbbs_checker.sv =====
// Checker for the grid bracket binary search block: watches the three channels,
// predicts each bracket from its own grid copy and compares. Uses gbbs_pkg.
module gbbs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_action,
    input  logic [gbbs_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [gbbs_pkg::VAL_W-1:0] i_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [gbbs_pkg::IDX_W-1:0]        i_lower_index,
    input  logic [gbbs_pkg::IDX_W-1:0]        i_upper_index,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [gbbs_pkg::LEN_W-1:0]        i_cfg_grid_length,
    input  logic                              i_flush,
    output int                                o_error_count
);
    import gbbs_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] lower;
        logic [IDX_W-1:0] upper;
    } t_bracket;

    logic signed [VAL_W-1:0] grid_mem [DEPTH];
    logic [LEN_W-1:0]        len_q = LEN_RESET;
    t_bracket                brackets [$];
    int                      err_count = 0;
    bit                      flushed = 1'b0;

    assign o_error_count = err_count;

    // First entry at or above the value among entries 1..n-1, clamped to n-1.
    function automatic logic [IDX_W-1:0] locate_upper(logic signed [VAL_W-1:0] v);
        int n;
        int first;
        int count;
        int half;
        int probe;
        if (len_q < LEN_MIN)
            n = 2;
        else if (len_q > LEN_MAX)
            n = DEPTH;
        else
            n = int'(len_q);
        first = 1;
        count = n - 1;
        while (count > 0) begin
            half  = count / 2;
            probe = first + half;
            if (grid_mem[probe] < v) begin
                first = probe + 1;
                count = count - half - 1;
            end else begin
                count = half;
            end
        end
        if (first == n)
            first = n - 1;
        return IDX_W'(first);
    endfunction

    always @(posedge i_clk) begin
        t_bracket         want;
        logic [IDX_W-1:0] up;
        if (!i_rst_n) begin
            len_q = LEN_RESET;
            brackets.delete();
        end else begin
            // Retire the result before taking a new search in the same cycle.
            if (i_out_valid && i_out_ready) begin
                if (brackets.size() == 0) begin
                    $display("%0t: unexpected result lower %0d upper %0d", $time,
                             i_lower_index, i_upper_index);
                    err_count++;
                end else begin
                    want = brackets.pop_front();
                    if (i_lower_index !== want.lower) begin
                        $display("%0t: lower_index mismatch: expected %0d, got %0d",
                                 $time, want.lower, i_lower_index);
                        err_count++;
                    end
                    if (i_upper_index !== want.upper) begin
                        $display("%0t: upper_index mismatch: expected %0d, got %0d",
                                 $time, want.upper, i_upper_index);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_WRITE) begin
                    grid_mem[i_entry_index] = i_value;
                end else begin
                    up = locate_upper(i_value);
                    brackets.push_back('{lower: up - 1'b1, upper: up});
                end
            end
            // A length written at this edge applies from the next transaction on.
            if (i_cfg_valid && i_cfg_ready)
                len_q = i_cfg_grid_length;
            if (i_flush && !flushed) begin
                flushed = 1'b1;
                if (brackets.size() != 0) begin
                    $display("%0t: %0d results never arrived: expected lower %0d upper %0d",
                             $time, brackets.size(), brackets[0].lower, brackets[0].upper);
                    err_count += brackets.size();
                end
            end
        end
    end

endmodule

// ===== dv/tb_grid_bracket_binary_search.sv =====
// Testbench top for grid_bracket_binary_search: drives grid writes, searches and
// length settings with random idling. Uses gbbs_pkg and gbbs_checker.
module tb_grid_bracket_binary_search;
    import gbbs_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    in_action;
    logic [IDX_W-1:0]        in_entry_index;
    logic signed [VAL_W-1:0] in_value;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [IDX_W-1:0]        out_lower;
    logic [IDX_W-1:0]        out_upper;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [LEN_W-1:0]        cfg_len;
    logic                    flush;
    int                      error_count;

    logic signed [VAL_W-1:0] shadow [DEPTH];
    int  items = 0;
    int  writes_sent = 0;
    int  searches_sent = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  sink_hold = 0;
    bit  src_gaps = 1'b1;
    bit  sink_gaps = 1'b1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    grid_bracket_binary_search u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_action          (in_action),
        .i_entry_index     (in_entry_index),
        .i_value           (in_value),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_lower_index     (out_lower),
        .o_upper_index     (out_upper),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_grid_length (cfg_len)
    );

    gbbs_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_action          (in_action),
        .i_entry_index     (in_entry_index),
        .i_value           (in_value),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_lower_index     (out_lower),
        .i_upper_index     (out_upper),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_grid_length (cfg_len),
        .i_flush           (flush),
        .o_error_count     (error_count)
    );

    // Result receiver: stall a random number of cycles after each transaction.
    always @(posedge clk) begin
        int hold;
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_hold <= 0;
        end else if (out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            hold = sink_gaps ? $urandom_range(0, 15) : 0;
            if (hold != 0) begin
                out_ready <= 1'b0;
                sink_hold <= hold;
            end
        end else if (!out_ready) begin
            if (sink_hold > 1)
                sink_hold <= sink_hold - 1;
            else
                out_ready <= 1'b1;
        end
    end

    function automatic int eff_len(logic [LEN_W-1:0] len);
        if (len < LEN_MIN)
            return 2;
        if (len > LEN_MAX)
            return DEPTH;
        return int'(len);
    endfunction

    // Search value aimed at the grid: hits, neighbors, gaps, both ends, random values and the range extremes.
    function automatic logic signed [VAL_W-1:0] pick_probe(int n);
        int     k;
        longint a;
        longint b;
        k = $urandom_range(1, n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return shadow[k];
            2: return shadow[k] + 1;
            3: return shadow[k] - 1;
            4: return shadow[1] - VAL_W'($urandom_range(1, 1000));
            5: return shadow[n - 1] + VAL_W'($urandom_range(1, 1000));
            6: return 32'sh8000_0000;
            7: return 32'sh7fff_ffff;
            default: begin
                if (n < 3)
                    return shadow[1];
                k = $urandom_range(1, n - 2);
                a = shadow[k];
                b = shadow[k + 1];
                return VAL_W'((a + b) >>> 1);
            end
        endcase
    endfunction

    task automatic send(input logic act, input logic [IDX_W-1:0] idx,
                        input logic signed [VAL_W-1:0] val);
        int gap;
        gap = src_gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_action      <= act;
        in_entry_index <= idx;
        in_value       <= val;
        do @(posedge clk); while (!in_ready);
        items++;
        if (act == ACT_SEARCH)
            searches_sent++;
        else
            writes_sent++;
    endtask

    task automatic write_entry(input int idx, input logic signed [VAL_W-1:0] val);
        shadow[idx] = val;
        send(ACT_WRITE, IDX_W'(idx), val);
    endtask

    task automatic search(input logic signed [VAL_W-1:0] val);
        send(ACT_SEARCH, IDX_W'($urandom), val);
    endtask

    // Drain outstanding searches, then let a trailing write settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_seen != searches_sent) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_len   <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Write entries 0..n-1 in ascending order; small steps give duplicates.
    task automatic load_grid(input int n, input int unsigned step_max);
        longint v;
        longint span;
        bit     top_at_max;
        span = longint'(n) * step_max;
        if ($urandom_range(0, 3) == 0)
            v = -64'sd2147483648;
        else
            v = -64'sd2147483648 + longint'($urandom) % (64'sd4294967296 - span);
        top_at_max = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1 && top_at_max)
                v = 64'sd2147483647;
            write_entry(i, VAL_W'(v));
            v += $urandom_range(0, step_max);
        end
    endtask

    initial begin
        logic [LEN_W-1:0] len;
        int               n;
        int unsigned      step_max;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_action      <= ACT_WRITE;
        in_entry_index <= '0;
        in_value       <= '0;
        cfg_valid      <= 1'b0;
        cfg_len        <= LEN_RESET;
        flush          <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Length zero runs as two: only entry 1 is probed.
        set_length(11'd0);
        write_entry(0, 32'sh8000_0000);
        write_entry(1, 32'sh0000_0000);
        search(32'sh8000_0000);
        search(32'sh7fff_ffff);
        search(32'sh0000_0000);
        search(-32'sd1);
        search(32'sh0000_0001);
        set_length(11'd1);
        search(32'sh8000_0000);
        search(32'sh7fff_ffff);
        set_length(11'd4);
        write_entry(2, 32'sh0001_0000);
        write_entry(3, 32'sh7fff_ffff);
        search(32'sh7fff_ffff);
        search(32'sh0000_8000);
        search(32'sh0001_0001);
        // Lower the top entry so the maximum lies above the grid.
        write_entry(3, 32'sh0002_0000);
        search(32'sh7fff_ffff);

        // Fill the whole store so any length can be searched from here on.
        set_length(LEN_MAX);
        load_grid(DEPTH, 4_000_000);
        repeat (40) search(pick_probe(DEPTH));

        while (items < 1300) begin
            case ($urandom_range(0, 9))
                0: len = LEN_MAX;
                1: len = LEN_W'($urandom_range(DEPTH + 1, 2047));
                2: len = LEN_W'($urandom_range(0, 1));
                3: len = LEN_W'($urandom_range(2, DEPTH));
                default: len = LEN_W'($urandom_range(2, 48));
            endcase
            set_length(len);
            n = eff_len(len);
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            if (n <= 64) begin
                case ($urandom_range(0, 2))
                    0: step_max = 3;
                    1: step_max = 5000;
                    default: step_max = 1 << 24;
                endcase
                load_grid(n, step_max);
            end
            repeat ($urandom_range(8, 30)) begin
                if ($urandom_range(0, 19) == 0)
                    write_entry($urandom_range(0, DEPTH - 1), $urandom);
                else
                    search(pick_probe(n));
            end
        end

        in_valid <= 1'b0;
        while (results_seen != searches_sent) @(posedge clk);
        repeat (20) @(posedge clk);
        flush <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Covered %0d grid writes, %0d searches and %0d length settings,",
                 writes_sent, searches_sent, cfg_writes);
        $display("from length 0 to 2047, with %0d brackets checked.", results_seen);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timeout: %0d of %0d results received", results_seen, searches_sent);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
